// ===== sv/frustum_cull_tester_top_defines.svh =====
// Assertion macros used by the checker file of the frustum cull tester.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef FRUSTUM_CULL_TESTER_TOP_DEFINES_SVH
`define FRUSTUM_CULL_TESTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frustum cull tester check failed");

// Next-cycle implication, disabled while reset is high.
`define FCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frustum cull tester check failed");

`endif

// ===== sv/fct_pkg.sv =====
package fct_pkg;

  // Number formats.
  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int SHIFT_W   = PROD_W - FRAC_BITS;
  localparam int SUM_W     = SHIFT_W + 2;

  // Plane store.
  localparam int NUM_PLANES = 6;
  localparam int PIDX_W     = 3;
  localparam int NEAR_PLANE = 5;
  localparam int LAST_PLANE = NUM_PLANES - 1;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_POINT  = 2'd1,
    REQ_SPHERE = 2'd2,
    REQ_BOX    = 2'd3
  } req_t;

  // Whole-box classes.
  localparam logic [1:0] WHOLE_OUT     = 2'd0;
  localparam logic [1:0] WHOLE_PARTIAL = 2'd1;
  localparam logic [1:0] WHOLE_INSIDE  = 2'd2;

  // Near-plane classes.
  localparam logic [1:0] NEAR_CULLED   = 2'd0;
  localparam logic [1:0] NEAR_FRONT    = 2'd1;
  localparam logic [1:0] NEAR_STRADDLE = 2'd2;

  // One stored plane.
  typedef struct packed {
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    logic [COORD_W-1:0] nz;
    logic [COORD_W-1:0] off;
  } plane_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

endpackage

// ===== sv/frustum_cull_tester_top.sv =====
// Six-plane frustum culling tester, signed Q16.16.
// Input channel (in_valid/in_ready) carries one beat per request: a plane
// load, a point test, a sphere test or one box corner. Output channel
// (out_valid/out_ready) carries one beat per point or sphere test and one
// per box, after the corner marked corner_last.
// A plane load is written straight to the plane memory and leaves the block ready.
// A test or corner beat reads the six planes from the plane memory one per
// cycle into a single three-multiplier dot-product unit, then a sum and
// saturate stage. The result is loaded into the output register from the
// finish state, and no new beat is taken until the block is back in idle.
// The result sits in an output register, so the block goes on to the next
// request while it waits; only a second result that finds the register
// still full holds the block until out_ready takes the first.
// Reset clears all planes to zero (through per-plane valid bits), clears
// the box accumulators and empties the output register.
module frustum_cull_tester_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  req_type,
  input  logic [2:0]                  plane_index,
  input  logic [fct_pkg::COORD_W-1:0] coord_x,
  input  logic [fct_pkg::COORD_W-1:0] coord_y,
  input  logic [fct_pkg::COORD_W-1:0] coord_z,
  input  logic [fct_pkg::COORD_W-1:0] extra_value,
  input  logic                        corner_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  test_kind,
  output logic                        visible,
  output logic [1:0]                  whole_class,
  output logic [1:0]                  near_class
);
  import fct_pkg::*;

  localparam logic [COORD_W-1:0] DIST_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] DIST_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Plane memory and its valid bits.
  plane_t                plane_mem [NUM_PLANES];
  logic [NUM_PLANES-1:0] plane_vld;

  // Current request.
  req_t               item_req;
  logic [COORD_W-1:0] item_x;
  logic [COORD_W-1:0] item_y;
  logic [COORD_W-1:0] item_z;
  logic [COORD_W-1:0] item_ext;
  logic               item_last;

  // Sequencer.
  state_t state;
  state_t state_next;
  logic   in_fire;
  logic   test_fire;
  logic   res_load;

  // Read issue and pipeline.
  logic              issue_busy;
  logic [PIDX_W-1:0] issue_idx;
  logic              s1_valid;
  logic [PIDX_W-1:0] s1_idx;
  plane_t            mem_q;
  logic              vld_q;
  plane_t            rd_plane;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic signed [PROD_W-1:0] prod_z;
  logic              s2_valid;
  logic [PIDX_W-1:0] s2_idx;
  logic [SHIFT_W-1:0] s2_px;
  logic [SHIFT_W-1:0] s2_py;
  logic [SHIFT_W-1:0] s2_pz;
  logic [COORD_W-1:0] s2_off;

  // Distance.
  logic [SUM_W-1:0]   dist_sum;
  logic               dist_ovf;
  logic [COORD_W-1:0] dist_sat;
  logic [COORD_W:0]   dist_plus_r;
  logic               dist_neg;
  logic               dist_pos;

  // Per-test flags and box accumulators.
  logic                  fail;
  logic                  near_lt;
  logic [NUM_PLANES-1:0] box_any_front;
  logic [NUM_PLANES-1:0] box_all_front;
  logic                  box_near_behind;

  // Result.
  logic       res_vis;
  logic [1:0] res_whole;
  logic [1:0] res_near;

  assign in_fire   = in_valid && in_ready;
  assign test_fire = in_fire && (req_t'(req_type) != REQ_LOAD);

  // Plane loads write the memory directly; out-of-range indexes are dropped.
  always_ff @(posedge clk) begin
    if (in_fire && (req_t'(req_type) == REQ_LOAD) && (plane_index < PIDX_W'(NUM_PLANES))) begin
      plane_mem[plane_index] <= plane_t'({coord_x, coord_y, coord_z, extra_value});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_vld <= '0;
    end else if (in_fire && (req_t'(req_type) == REQ_LOAD) &&
                 (plane_index < PIDX_W'(NUM_PLANES))) begin
      plane_vld[plane_index] <= 1'b1;
    end
  end

  // Capture the request payload.
  always_ff @(posedge clk) begin
    if (test_fire) begin
      item_req  <= req_t'(req_type);
      item_x    <= coord_x;
      item_y    <= coord_y;
      item_z    <= coord_z;
      item_ext  <= extra_value;
      item_last <= corner_last;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (test_fire) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (s2_valid && (s2_idx == PIDX_W'(LAST_PLANE))) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if ((item_req == REQ_BOX) && !item_last) begin
          state_next = ST_IDLE;
        end else if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = 1'b0;
    res_load = 1'b0;
    unique case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_RUN:    in_ready = 1'b0;
      ST_FINISH: res_load = !((item_req == REQ_BOX) && !item_last) &&
                            (!out_valid || out_ready);
      default:   in_ready = 1'b0;
    endcase
  end

  // Issue one plane read per cycle, planes in order.
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_busy <= 1'b0;
      issue_idx  <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
    end else begin
      s1_valid <= issue_busy;
      s2_valid <= s1_valid;
      if (test_fire) begin
        issue_busy <= 1'b1;
        issue_idx  <= '0;
      end else if (issue_busy) begin
        issue_idx <= issue_idx + 1'b1;
        if (issue_idx == PIDX_W'(LAST_PLANE)) begin
          issue_busy <= 1'b0;
        end
      end
    end
  end

  // Synchronous memory read.
  always_ff @(posedge clk) begin
    if (issue_busy) begin
      mem_q  <= plane_mem[issue_idx];
      vld_q  <= plane_vld[issue_idx];
      s1_idx <= issue_idx;
    end
  end

  // A plane never loaded reads as zero.
  assign rd_plane = vld_q ? mem_q : '0;

  // Dot-product multipliers.
  assign prod_x = $signed(rd_plane.nx) * $signed(item_x);
  assign prod_y = $signed(rd_plane.ny) * $signed(item_y);
  assign prod_z = $signed(rd_plane.nz) * $signed(item_z);

  // Products floored to the coordinate fraction and registered.
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_idx <= s1_idx;
      s2_px  <= prod_x[PROD_W-1:FRAC_BITS];
      s2_py  <= prod_y[PROD_W-1:FRAC_BITS];
      s2_pz  <= prod_z[PROD_W-1:FRAC_BITS];
      s2_off <= rd_plane.off;
    end
  end

  // Exact sum, then saturate to the coordinate width.
  assign dist_sum = {{2{s2_px[SHIFT_W-1]}}, s2_px} + {{2{s2_py[SHIFT_W-1]}}, s2_py} +
                    {{2{s2_pz[SHIFT_W-1]}}, s2_pz} +
                    {{(SUM_W-COORD_W){s2_off[COORD_W-1]}}, s2_off};
  assign dist_ovf = (dist_sum[SUM_W-1:COORD_W-1] !=
                     {(SUM_W-COORD_W+1){dist_sum[SUM_W-1]}});
  assign dist_sat = dist_ovf ? (dist_sum[SUM_W-1] ? DIST_MIN : DIST_MAX)
                             : dist_sum[COORD_W-1:0];

  // Comparisons against zero and against minus the radius.
  assign dist_plus_r = {dist_sat[COORD_W-1], dist_sat} + {item_ext[COORD_W-1], item_ext};
  assign dist_neg    = dist_sat[COORD_W-1];
  assign dist_pos    = !dist_sat[COORD_W-1] && (dist_sat != '0);

  // Accumulate per-plane outcomes.
  always_ff @(posedge clk) begin
    if (rst) begin
      box_any_front   <= '0;
      box_all_front   <= '1;
      box_near_behind <= 1'b0;
      fail            <= 1'b0;
      near_lt         <= 1'b0;
    end else begin
      if (test_fire) begin
        fail    <= 1'b0;
        near_lt <= 1'b0;
      end else if (s2_valid) begin
        unique case (item_req)
          REQ_POINT: begin
            if (dist_neg) begin
              fail <= 1'b1;
            end
          end
          REQ_SPHERE: begin
            if (dist_plus_r[COORD_W]) begin
              fail <= 1'b1;
            end
            if (s2_idx == PIDX_W'(NEAR_PLANE)) begin
              near_lt <= ($signed(dist_sat) < $signed(item_ext));
            end
          end
          REQ_BOX: begin
            if (dist_pos) begin
              box_any_front[s2_idx] <= 1'b1;
            end else begin
              box_all_front[s2_idx] <= 1'b0;
              if (s2_idx == PIDX_W'(NEAR_PLANE)) begin
                box_near_behind <= 1'b1;
              end
            end
          end
          REQ_LOAD: begin
            fail <= fail;
          end
          default: fail <= fail;
        endcase
      end else if (res_load && (item_req == REQ_BOX)) begin
        box_any_front   <= '0;
        box_all_front   <= '1;
        box_near_behind <= 1'b0;
      end
    end
  end

  // Result fields.
  always_comb begin
    res_vis   = 1'b0;
    res_whole = WHOLE_OUT;
    res_near  = NEAR_CULLED;
    unique case (item_req)
      REQ_POINT: begin
        res_vis   = !fail;
        res_whole = res_vis ? WHOLE_PARTIAL : WHOLE_OUT;
        res_near  = res_vis ? NEAR_FRONT : NEAR_CULLED;
      end
      REQ_SPHERE: begin
        res_vis   = !fail;
        res_whole = res_vis ? WHOLE_PARTIAL : WHOLE_OUT;
        res_near  = !res_vis ? NEAR_CULLED : (near_lt ? NEAR_STRADDLE : NEAR_FRONT);
      end
      REQ_BOX: begin
        res_vis   = &box_any_front;
        res_whole = !res_vis ? WHOLE_OUT : ((&box_all_front) ? WHOLE_INSIDE : WHOLE_PARTIAL);
        res_near  = !res_vis ? NEAR_CULLED : (box_near_behind ? NEAR_STRADDLE : NEAR_FRONT);
      end
      REQ_LOAD: begin
        res_vis = 1'b0;
      end
      default: res_vis = 1'b0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      test_kind   <= item_req;
      visible     <= res_vis;
      whole_class <= res_whole;
      near_class  <= res_near;
    end
  end

endmodule

// ===== sv/fct_checker.sv =====
`include "frustum_cull_tester_top_defines.svh"

module fct_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] req_type,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] test_kind,
  input logic       visible,
  input logic [1:0] whole_class,
  input logic [1:0] near_class
);
  import fct_pkg::*;

  // A stalled result beat holds its payload.
  `FCT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(test_kind) && $stable(visible) && $stable(whole_class) && $stable(near_class))

  // Loads never produce a result beat.
  `FCT_ASSERT_NOW(a_no_load_result, out_valid, test_kind != REQ_LOAD)

  // Culled results carry zero classes, visible ones carry nonzero classes.
  `FCT_ASSERT_NOW(a_class_match, out_valid, (visible == (whole_class != WHOLE_OUT)) && (visible == (near_class != NEAR_CULLED)))

  // A point result never reports straddling or wholly inside.
  `FCT_ASSERT_NOW(a_point_class, out_valid && (test_kind == REQ_POINT), (whole_class == {1'b0, visible}) && (near_class == {1'b0, visible}))

  // Accepting a test beat makes the block busy in the next cycle.
  `FCT_ASSERT_NEXT(a_busy_after_test, in_valid && in_ready && (req_type != REQ_LOAD), !in_ready)

endmodule

bind frustum_cull_tester_top fct_checker u_fct_checker (.*);

// ===== verif/frustum_cull_tester_top_tb.sv =====
module frustum_cull_tester_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fct_pkg::*;

  localparam int ONE = 1 << FRAC_BITS;
  localparam int QUIET_AT = 1050;
  localparam int ITEM_COUNT = 1200;
  localparam longint DIST_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint DIST_MIN = -DIST_MAX - 1;

  // One request beat as the sender drives it.
  typedef struct {
    req_t                      req;
    logic [2:0]                idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] e;
    logic                      last;
  } cull_beat_t;

  // One result beat as the block returns it.
  typedef struct packed {
    logic [1:0] kind;
    logic       vis;
    logic [1:0] whole;
    logic [1:0] near_cls;
  } cull_result_t;

  // Holds its own copy of the plane store and box accumulators, predicts
  // each test outcome and compares it with what the block returns.
  class cull_scoreboard;
    logic signed [COORD_W-1:0] nrm_x[NUM_PLANES];
    logic signed [COORD_W-1:0] nrm_y[NUM_PLANES];
    logic signed [COORD_W-1:0] nrm_z[NUM_PLANES];
    logic signed [COORD_W-1:0] offs[NUM_PLANES];
    logic [NUM_PLANES-1:0]     any_front;
    logic [NUM_PLANES-1:0]     all_front;
    logic                      near_behind;
    cull_result_t              expected_q[$];
    int                        errors;

    function new();
      for (int i = 0; i < NUM_PLANES; i++) begin
        nrm_x[i] = '0;
        nrm_y[i] = '0;
        nrm_z[i] = '0;
        offs[i]  = '0;
      end
      clear_box();
      errors = 0;
    endfunction

    function void clear_box();
      any_front   = '0;
      all_front   = '1;
      near_behind = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Signed distance of a point from plane i. Each product is floored to
    // the fraction width, the terms are summed exactly, then saturated.
    function longint plane_distance(int i, logic signed [COORD_W-1:0] x,
                                    logic signed [COORD_W-1:0] y,
                                    logic signed [COORD_W-1:0] z);
      longint s;
      s = ((longint'(nrm_x[i]) * longint'(x)) >>> FRAC_BITS)
        + ((longint'(nrm_y[i]) * longint'(y)) >>> FRAC_BITS)
        + ((longint'(nrm_z[i]) * longint'(z)) >>> FRAC_BITS)
        + longint'(offs[i]);
      if (s > DIST_MAX) return DIST_MAX;
      if (s < DIST_MIN) return DIST_MIN;
      return s;
    endfunction

    // Called once per accepted input beat.
    function void note_beat(cull_beat_t b);
      longint d;
      longint nd;
      longint rad;
      logic vis;
      cull_result_t r;
      vis = 1'b1;
      nd  = 0;
      rad = longint'(b.e);
      case (b.req)
        REQ_LOAD: begin
          if (b.idx < NUM_PLANES) begin
            nrm_x[b.idx] = b.x;
            nrm_y[b.idx] = b.y;
            nrm_z[b.idx] = b.z;
            offs[b.idx]  = b.e;
          end
        end
        REQ_POINT: begin
          for (int i = 0; i < NUM_PLANES; i++)
            if (plane_distance(i, b.x, b.y, b.z) < 0) vis = 1'b0;
          r.kind     = REQ_POINT;
          r.vis      = vis;
          r.whole    = vis ? WHOLE_PARTIAL : WHOLE_OUT;
          r.near_cls = vis ? NEAR_FRONT : NEAR_CULLED;
          expected_q.push_back(r);
        end
        REQ_SPHERE: begin
          for (int i = 0; i < NUM_PLANES; i++) begin
            d = plane_distance(i, b.x, b.y, b.z);
            if (d < -rad) vis = 1'b0;
            if (i == NEAR_PLANE) nd = d;
          end
          r.kind     = REQ_SPHERE;
          r.vis      = vis;
          r.whole    = vis ? WHOLE_PARTIAL : WHOLE_OUT;
          r.near_cls = !vis ? NEAR_CULLED : (nd < rad) ? NEAR_STRADDLE : NEAR_FRONT;
          expected_q.push_back(r);
        end
        default: begin
          for (int i = 0; i < NUM_PLANES; i++) begin
            d = plane_distance(i, b.x, b.y, b.z);
            if (d > 0) begin
              any_front[i] = 1'b1;
            end else begin
              all_front[i] = 1'b0;
              if (i == NEAR_PLANE) near_behind = 1'b1;
            end
          end
          if (b.last) begin
            r.kind = REQ_BOX;
            if (any_front != '1) begin
              r.vis      = 1'b0;
              r.whole    = WHOLE_OUT;
              r.near_cls = NEAR_CULLED;
            end else begin
              r.vis      = 1'b1;
              r.whole    = (all_front == '1) ? WHOLE_INSIDE : WHOLE_PARTIAL;
              r.near_cls = near_behind ? NEAR_STRADDLE : NEAR_FRONT;
            end
            expected_q.push_back(r);
            clear_box();
          end
        end
      endcase
    endfunction

    // Called once per accepted result beat.
    function void check_result(cull_result_t got);
      cull_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind %0d visible %0d whole %0d near %0d",
                   got.kind, got.vis, got.whole, got.near_cls);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"result mismatch: expected kind %0d visible %0d whole %0d near %0d,",
                    " got kind %0d visible %0d whole %0d near %0d"},
                   want.kind, want.vis, want.whole, want.near_cls,
                   got.kind, got.vis, got.whole, got.near_cls);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         req_type = '0;
  logic [2:0]         plane_index = '0;
  logic [COORD_W-1:0] coord_x = '0;
  logic [COORD_W-1:0] coord_y = '0;
  logic [COORD_W-1:0] coord_z = '0;
  logic [COORD_W-1:0] extra_value = '0;
  logic               corner_last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         test_kind;
  logic               visible;
  logic [1:0]         whole_class;
  logic [1:0]         near_class;

  cull_scoreboard sb = new();
  bit quiet = 1'b0;
  bit idle_on = 1'b1;
  int items_sent = 0;
  int next_drain = 400;

  frustum_cull_tester_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .plane_index (plane_index),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .extra_value (extra_value),
    .corner_last (corner_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .test_kind   (test_kind),
    .visible     (visible),
    .whole_class (whole_class),
    .near_class  (near_class)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [COORD_W-1:0] fx(int units);
    return units * ONE;
  endfunction

  // Value in [-mag, mag]: a uniform magnitude with a random sign.
  function automatic logic signed [COORD_W-1:0] rnd_fix(int unsigned mag);
    logic signed [COORD_W-1:0] v;
    v = $urandom_range(mag);
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  // Mostly a moderate value, sometimes any 32-bit pattern or an extreme.
  function automatic logic signed [COORD_W-1:0] rnd_coord(int unsigned mag);
    case ($urandom_range(15))
      0: return $urandom;
      1: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return rnd_fix(mag);
    endcase
  endfunction

  function automatic cull_beat_t make_beat(req_t req, int idx,
                                           logic signed [COORD_W-1:0] x,
                                           logic signed [COORD_W-1:0] y,
                                           logic signed [COORD_W-1:0] z,
                                           logic signed [COORD_W-1:0] e,
                                           int last);
    cull_beat_t b;
    b.req  = req;
    b.idx  = 3'(idx);
    b.x    = x;
    b.y    = y;
    b.z    = z;
    b.e    = e;
    b.last = 1'(last);
    return b;
  endfunction

  // Present one beat and hold it until the block takes it.
  task automatic send_beat(cull_beat_t b);
    in_valid    <= 1'b1;
    req_type    <= b.req;
    plane_index <= b.idx;
    coord_x     <= b.x;
    coord_y     <= b.y;
    coord_z     <= b.z;
    extra_value <= b.e;
    corner_last <= b.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_beat(b);
  endtask

  // Optional idle burst or full drain ahead of a beat, then the beat itself.
  task automatic issue(cull_beat_t b);
    bit drain;
    int gap;
    drain = 1'b0;
    gap   = 0;
    if (items_sent >= next_drain) begin
      drain = 1'b1;
      next_drain += 400;
    end
    if (!quiet && idle_on && $urandom_range(3) == 0) gap = $urandom_range(1, 14);
    if (drain || gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) begin
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
    end
    send_beat(b);
    if (!(b.req == REQ_LOAD && b.idx >= NUM_PLANES)) items_sent++;
    if (items_sent >= QUIET_AT) quiet = 1'b1;
    if ($urandom_range(40) == 0) idle_on = !idle_on;
  endtask

  // Six roughly axis-aligned planes around the origin, near plane facing +z.
  task automatic load_frustum();
    logic signed [COORD_W-1:0] n[3];
    logic signed [COORD_W-1:0] off;
    int axis;
    for (int i = 0; i < NUM_PLANES; i++) begin
      axis = (i < 4) ? i / 2 : 2;
      for (int a = 0; a < 3; a++) n[a] = rnd_fix(ONE / 4);
      n[axis] = ONE + rnd_fix(ONE / 4);
      if (i == 1 || i == 3 || i == 4) n[axis] = -n[axis];
      if (i == NEAR_PLANE) off = -$signed($urandom_range(4 * ONE));
      else off = $urandom_range(40 * ONE, 5 * ONE);
      issue(make_beat(REQ_LOAD, i, n[0], n[1], n[2], off, $urandom_range(1)));
    end
  endtask

  task automatic send_point();
    issue(make_beat(REQ_POINT, $urandom_range(7), rnd_coord(40 * ONE),
                    rnd_coord(40 * ONE), rnd_coord(40 * ONE), $urandom,
                    $urandom_range(1)));
  endtask

  task automatic send_sphere();
    logic signed [COORD_W-1:0] rad;
    case ($urandom_range(15))
      0, 1: rad = -$signed($urandom_range(5 * ONE));
      2: rad = rnd_coord(20 * ONE);
      default: rad = $urandom_range(15 * ONE);
    endcase
    issue(make_beat(REQ_SPHERE, $urandom_range(7), rnd_coord(40 * ONE),
                    rnd_coord(40 * ONE), rnd_coord(40 * ONE), rad,
                    $urandom_range(1)));
  endtask

  // A plane load with wide values; indexes 6 and 7 are dropped by the block.
  task automatic send_wild_load();
    issue(make_beat(REQ_LOAD, $urandom_range(7), rnd_coord(2 * ONE),
                    rnd_coord(2 * ONE), rnd_coord(2 * ONE), rnd_coord(40 * ONE),
                    $urandom_range(1)));
  endtask

  // A box of 1 to 8 corners around a random center, with the odd
  // unrelated request slipped in between corners.
  task automatic send_box();
    logic signed [COORD_W-1:0] cx, cy, cz, h, px, py, pz;
    int n;
    cx = rnd_fix(30 * ONE);
    cy = rnd_fix(30 * ONE);
    cz = $signed($urandom_range(25 * ONE)) - fx(2);
    h  = $urandom_range(12 * ONE);
    n  = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(11) == 0) begin
        case ($urandom_range(2))
          0: send_point();
          1: send_sphere();
          default: send_wild_load();
        endcase
      end
      px = k[0] ? cx + h : cx - h;
      py = k[1] ? cy + h : cy - h;
      pz = k[2] ? cz + h : cz - h;
      if ($urandom_range(9) == 0) begin
        px = rnd_coord(40 * ONE);
        pz = rnd_coord(40 * ONE);
      end
      issue(make_beat(REQ_BOX, $urandom_range(7), px, py, pz, $urandom, k == n - 1));
    end
  endtask

  // Result side: check each accepted beat and stall in random bursts.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        sb.check_result(cull_result_t'{test_kind, visible, whole_class, near_class});
      if (stall > 0) stall--;
      else if (!quiet && $urandom_range(9) == 0) stall = $urandom_range(1, 14);
      out_ready <= (stall == 0);
    end
  end

  // Stimulus: directed cases first, then random traffic.
  initial begin
    int pick;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Planes are all zero after reset: every distance is exactly zero.
    issue(make_beat(REQ_POINT, 0, fx(0), fx(0), fx(0), fx(0), 1'b0));
    issue(make_beat(REQ_BOX, 0, fx(3), fx(-3), fx(1), fx(0), 1'b1));

    // Box frustum with unit normals: |x|,|y| <= 10, 1 <= z <= 20.
    issue(make_beat(REQ_LOAD, 0, fx(1), fx(0), fx(0), fx(10), 1'b0));
    issue(make_beat(REQ_LOAD, 1, fx(-1), fx(0), fx(0), fx(10), 1'b1));
    issue(make_beat(REQ_LOAD, 2, fx(0), fx(1), fx(0), fx(10), 1'b0));
    issue(make_beat(REQ_LOAD, 3, fx(0), fx(-1), fx(0), fx(10), 1'b0));
    issue(make_beat(REQ_LOAD, 4, fx(0), fx(0), fx(-1), fx(20), 1'b0));
    issue(make_beat(REQ_LOAD, NEAR_PLANE, fx(0), fx(0), fx(1), fx(-1), 1'b0));

    // Loads to nonexistent planes must leave the store alone.
    issue(make_beat(REQ_LOAD, 6, fx(5), fx(5), fx(5), fx(-100), 1'b0));
    issue(make_beat(REQ_LOAD, 7, '1, '1, '1, '1, 1'b1));

    // Points inside and outside.
    issue(make_beat(REQ_POINT, 0, fx(0), fx(0), fx(5), fx(0), 1'b0));
    issue(make_beat(REQ_POINT, 0, fx(11), fx(0), fx(5), fx(0), 1'b0));

    // Spheres: straddling the near plane, fully in front, negative radii.
    issue(make_beat(REQ_SPHERE, 0, fx(0), fx(0), ONE * 3 / 2, fx(1), 1'b0));
    issue(make_beat(REQ_SPHERE, 0, fx(0), fx(0), fx(5), fx(1), 1'b0));
    issue(make_beat(REQ_SPHERE, 0, fx(0), fx(0), fx(5), fx(-2), 1'b0));
    issue(make_beat(REQ_SPHERE, 0, fx(0), fx(0), fx(5), 32'h8000_0000, 1'b0));
    issue(make_beat(REQ_SPHERE, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 1'b0));

    // Box interrupted by a point test and a plane load, ending partial.
    issue(make_beat(REQ_BOX, 0, fx(0), fx(0), fx(5), fx(0), 1'b0));
    issue(make_beat(REQ_POINT, 0, fx(-20), fx(0), fx(5), fx(0), 1'b0));
    issue(make_beat(REQ_LOAD, 0, fx(1), fx(0), fx(0), fx(11), 1'b0));
    issue(make_beat(REQ_BOX, 0, fx(12), fx(0), ONE / 2, fx(0), 1'b1));

    // Single-corner box wholly inside, then a box that is culled.
    issue(make_beat(REQ_BOX, 0, fx(0), fx(0), fx(5), fx(0), 1'b1));
    issue(make_beat(REQ_BOX, 0, fx(15), fx(0), fx(5), fx(0), 1'b0));
    issue(make_beat(REQ_BOX, 0, fx(15), fx(3), fx(9), fx(0), 1'b1));

    // Extreme plane and point so the distance saturates.
    issue(make_beat(REQ_LOAD, 3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF, 1'b0));
    issue(make_beat(REQ_POINT, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    fx(0), 1'b0));

    // Random traffic.
    load_frustum();
    while (items_sent < ITEM_COUNT) begin
      pick = $urandom_range(99);
      if (pick < 4) load_frustum();
      else if (pick < 8) send_wild_load();
      else if (pick < 30) send_point();
      else if (pick < 55) send_sphere();
      else send_box();
    end
    in_valid <= 1'b0;

    // Drain, let the pipeline settle, then report.
    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("** frustum_cull_tester_top: PASSED **");
    else
      $display("** frustum_cull_tester_top: FAILED **");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("** frustum_cull_tester_top: FAILED **");
    $finish;
  end

endmodule
